/* rtl/core/oversample_average_linear_scaler_defines.svh */
// Assertion macros shared by the scaler RTL.
// Uses the enclosing module's clk and active-low rst_n.
`ifndef OVERSAMPLE_AVERAGE_LINEAR_SCALER_DEFINES_SVH
`define OVERSAMPLE_AVERAGE_LINEAR_SCALER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define OALS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define OALS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OALS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define OALS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/oals_pkg.sv */
// Shared types and constants of the oversampling average scaler.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package oals_pkg;

    // Field widths
    localparam int SAMPLE_W    = 12;
    localparam int VALUE_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int DEF_SAMPLES = 16;

    // Divider operands: |dx * dy| and |input_high - input_low|
    localparam int NUM_W = (SAMPLE_W + 1) + (VALUE_W + 1);
    localparam int DEN_W = SAMPLE_W;
    // Mapped value before clamping
    localparam int MAP_W = NUM_W + 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_LOW,
        REG_INPUT_HIGH,
        REG_OUTPUT_LOW,
        REG_OUTPUT_HIGH
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_MUL,
        S_QUO_GO,
        S_QUO_WAIT,
        S_ADD,
        S_WRITE
    } seq_state_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic in_ready;
        logic div_start;
        logic avg_load;
        logic prod_load;
        logic quo_load;
        logic add_load;
        logic out_load;
    } seq_ctrl_t;

endpackage

/* rtl/core/oversample_average_linear_scaler.sv */
// Top level of the oversampling average scaler: registers, accumulator, mapping.
// Depends on oals_pkg, oals_seq, oals_div and the assertion header.
//
// Use: push 12-bit converter samples on the in channel (in_valid/in_ready,
// payload sample). Every SAMPLES samples close a window; the block then
// emits one beat on the out channel (out_valid/out_ready) carrying the
// truncated window average, the average mapped linearly from
// [input_low, input_high] onto [output_low, output_high] and clamped, and
// an invalid flag for a degenerate range (scaled_value is then zero).
// Registers are written through the cfg channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high. Write them while idle.
// While a window fills, in_ready stays high. The closing sample holds
// in_ready low until its result is written, mostly while the 46-step
// one-bit-per-cycle divider of the mapping runs; the average itself is
// a reciprocal multiply. For a degenerate range the sequencer goes from
// the average straight to the write, skipping the multiply and divide.
// A stalled receiver leaves the result in the output register; samples of
// the next window are still taken, and the next window's result waits in
// the sequencer, with in_ready low, until the held beat is taken.
// Reset clears registers, sum and sample count; no result is pending.
`timescale 1ns / 1ps
`include "oversample_average_linear_scaler_defines.svh"

module oversample_average_linear_scaler #(
    parameter int SAMPLES = oals_pkg::DEF_SAMPLES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [oals_pkg::SAMPLE_W-1:0]     sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [oals_pkg::VALUE_W-1:0] scaled_value,
    output logic [oals_pkg::SAMPLE_W-1:0]     window_average,
    output logic                              invalid,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [oals_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [oals_pkg::VALUE_W-1:0]      cfg_data
);
    import oals_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES + 1);

    // Reciprocal of SAMPLES, exact for every window sum
    localparam int                 AVG_SHIFT = SUM_W + $clog2(SAMPLES);
    localparam int                 RECIP_W   = SUM_W + 2;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((longint'(1) << AVG_SHIFT) + SAMPLES - 1) / SAMPLES);

    // Configuration registers
    logic [SAMPLE_W-1:0]       input_low_reg;
    logic [SAMPLE_W-1:0]       input_high_reg;
    logic signed [VALUE_W-1:0] output_low_reg;
    logic signed [VALUE_W-1:0] output_high_reg;

    // Accumulator
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             last_sample;
    logic             in_fire;

    // Datapath
    seq_ctrl_t                 ctrl;
    logic                      bad;
    logic                      out_free;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quotient;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [SUM_W+RECIP_W-1:0]  avg_prod;
    logic [SAMPLE_W-1:0]       avg_next;
    logic [SAMPLE_W-1:0]       avg_reg;
    logic signed [SAMPLE_W:0]  dx;
    logic signed [VALUE_W:0]   dy;
    logic signed [SAMPLE_W:0]  din;
    logic signed [SAMPLE_W:0]  din_neg;
    logic [DEN_W-1:0]          din_abs;
    logic signed [NUM_W-1:0]   prod_next;
    logic signed [NUM_W-1:0]   prod_reg;
    logic [NUM_W-1:0]          prod_abs;
    logic                      quo_neg;
    logic signed [NUM_W:0]     quo_pos;
    logic signed [NUM_W:0]     quo_next;
    logic signed [NUM_W:0]     quo_reg;
    logic signed [MAP_W-1:0]   low_ext;
    logic signed [MAP_W-1:0]   high_ext;
    logic signed [MAP_W-1:0]   map_next;
    logic signed [MAP_W-1:0]   map_reg;
    logic signed [VALUE_W-1:0] scaled_next;

    // Output register
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] scaled_reg;
    logic [SAMPLE_W-1:0]       average_reg;
    logic                      invalid_reg;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_low_reg   <= '0;
            input_high_reg  <= '0;
            output_low_reg  <= '0;
            output_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INPUT_LOW:   input_low_reg   <= cfg_data[SAMPLE_W-1:0];
                REG_INPUT_HIGH:  input_high_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_OUTPUT_LOW:  output_low_reg  <= $signed(cfg_data);
                REG_OUTPUT_HIGH: output_high_reg <= $signed(cfg_data);
                default:         input_low_reg   <= input_low_reg;
            endcase
        end
    end

    // Accumulate the window; drop the sum once the average is taken
    assign in_ready    = ctrl.in_ready;
    assign in_fire     = in_valid && in_ready;
    assign last_sample = cnt_reg == CNT_W'(SAMPLES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            sum_reg <= sum_reg + SUM_W'(sample);
            cnt_reg <= last_sample ? '0 : cnt_reg + 1'b1;
        end
        else if (ctrl.avg_load)
        begin
            sum_reg <= '0;
        end
    end

    assign bad      = (input_low_reg == input_high_reg) || (output_low_reg == output_high_reg);
    assign out_free = !out_valid_reg || out_ready;

    oals_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .last_sample (last_sample),
        .div_done    (div_done),
        .bad         (bad),
        .out_free    (out_free),
        .ctrl        (ctrl)
    );

    // Window average: multiply by the reciprocal and keep the high bits
    assign avg_prod = sum_reg * AVG_RECIP;
    assign avg_next = avg_prod[AVG_SHIFT +: SAMPLE_W];

    // Divider operands: |dx*dy| by |din|
    assign din     = $signed({1'b0, input_high_reg}) - $signed({1'b0, input_low_reg});
    assign din_neg = -din;
    assign din_abs = din[SAMPLE_W] ? din_neg[SAMPLE_W-1:0] : din[SAMPLE_W-1:0];

    assign prod_abs = prod_reg[NUM_W-1] ? $unsigned(-prod_reg) : $unsigned(prod_reg);

    assign div_num = prod_abs;
    assign div_den = din_abs;

    oals_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Offset product and signed quotient
    assign dx        = $signed({1'b0, avg_reg}) - $signed({1'b0, input_low_reg});
    assign dy        = $signed({output_high_reg[VALUE_W-1], output_high_reg})
                     - $signed({output_low_reg[VALUE_W-1], output_low_reg});
    assign prod_next = dx * dy;

    assign quo_neg  = prod_reg[NUM_W-1] ^ din[SAMPLE_W];
    assign quo_pos  = $signed({1'b0, div_quotient});
    assign quo_next = quo_neg ? -quo_pos : quo_pos;

    // Add the low bound, then clamp low first and high second; a degenerate range gives zero
    assign low_ext  = MAP_W'(output_low_reg);
    assign high_ext = MAP_W'(output_high_reg);
    assign map_next = MAP_W'(quo_reg) + low_ext;

    always_comb
    begin
        if (bad)
        begin
            scaled_next = '0;
        end
        else if (map_reg < low_ext)
        begin
            scaled_next = output_low_reg;
        end
        else if (map_reg > high_ext)
        begin
            scaled_next = output_high_reg;
        end
        else
        begin
            scaled_next = map_reg[VALUE_W-1:0];
        end
    end

    // Datapath stage registers
    always_ff @(posedge clk)
    begin
        if (ctrl.avg_load)
        begin
            avg_reg <= avg_next;
        end
        if (ctrl.prod_load)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.quo_load)
        begin
            quo_reg <= quo_next;
        end
        if (ctrl.add_load)
        begin
            map_reg <= map_next;
        end
    end

    // Output beat: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            scaled_reg  <= scaled_next;
            average_reg <= avg_reg;
            invalid_reg <= bad;
        end
    end

    assign out_valid      = out_valid_reg;
    assign scaled_value   = scaled_reg;
    assign window_average = average_reg;
    assign invalid        = invalid_reg;

    `OALS_ASSERT_NEXT(a_close_stalls_input, in_fire && last_sample, !in_ready, "input not held")
    `OALS_ASSERT_IMPLY(a_invalid_zero, out_valid && invalid, scaled_value == '0, "invalid not zero")
    `OALS_ASSERT_IMPLY(a_load_when_free, ctrl.out_load, out_free, "result loaded over a beat")

endmodule

/* rtl/core/oals_div.sv */
// Restoring divider, one quotient bit per cycle while busy.
// Depends on oals_pkg for default widths and the assertion header.
`timescale 1ns / 1ps
`include "oversample_average_linear_scaler_defines.svh"

module oals_div #(
    parameter int NUM_W = oals_pkg::NUM_W,
    parameter int DEN_W = oals_pkg::DEN_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    import oals_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              fits;

    // Trial subtract of the shifted remainder
    assign shifted  = {rem_reg, quo_reg[NUM_W-1]};
    assign fits     = shifted >= {1'b0, den_reg};
    assign diff     = shifted - {1'b0, den_reg};
    assign rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift one quotient bit in per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `OALS_ASSERT_IMPLY(a_no_restart, start, !busy_reg, "divider restarted while busy")
    `OALS_ASSERT_NEXT(a_busy_after_start, start, busy_reg, "divider idle after start")
    `OALS_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg && !busy_reg, "done not a single pulse")

endmodule

/* rtl/core/oals_seq.sv */
// Sequencer of the scaler: average, multiply, divide, add, clamp, write; a degenerate range skips to write.
// Depends on oals_pkg for the state and control types.
`timescale 1ns / 1ps

module oals_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  last_sample,
    input  logic                  div_done,
    input  logic                  bad,
    input  logic                  out_free,
    output oals_pkg::seq_ctrl_t   ctrl
);
    import oals_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && last_sample)
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:      state_next = bad ? S_WRITE : S_MUL;
            S_MUL:      state_next = S_QUO_GO;
            S_QUO_GO:   state_next = S_QUO_WAIT;
            S_QUO_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:      state_next = S_WRITE;
            S_WRITE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Controls
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            S_IDLE:     ctrl.in_ready = 1'b1;
            S_AVG:      ctrl.avg_load = 1'b1;
            S_MUL:      ctrl.prod_load = 1'b1;
            S_QUO_GO:   ctrl.div_start = 1'b1;
            S_QUO_WAIT: ctrl.quo_load = div_done;
            S_ADD:      ctrl.add_load = 1'b1;
            S_WRITE:    ctrl.out_load = out_free;
            default:    ctrl = '0;
        endcase
    end

endmodule
